// ===== hdl/lepton_cone_isolation_assert.svh =====
// Assertion macros shared by the lepton cone isolation RTL.
// Included by the top level; needs clock and reset in scope.
`ifndef LEPTON_CONE_ISOLATION_ASSERT_SVH
`define LEPTON_CONE_ISOLATION_ASSERT_SVH

// same-cycle implication, quiet during reset
`define LCI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lci check failed");

// next-cycle implication, quiet during reset
`define LCI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lci check failed");

// next-cycle implication, also checked across reset
`define LCI_ASSERT_NXT_NR(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lci check failed");

`endif

// ===== hdl/lci_pkg.sv =====
// Package for the lepton cone isolation block: field widths, codes,
// register reset values and the input item type. No dependencies.
`timescale 1ns / 1ps

package lci_pkg;

   localparam int PtW      = 16;
   localparam int EtaW     = 11;
   localparam int PhiW     = 10;
   localparam int PdgW     = 24;
   localparam int SumW     = 20;
   localparam int ConeW    = 22;
   localparam int RatioW   = 10;
   localparam int AbsEtaW  = 10;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 22;
   localparam int ProdW    = RatioW + PtW;
   localparam int DrW      = ConeW + 1;

   localparam logic [SumW-1:0]    SUM_MAX   = '1;
   localparam logic [EtaW-1:0]    CRACK_LO  = 11'd236;
   localparam logic [EtaW-1:0]    CRACK_HI  = 11'd255;
   localparam logic [PdgW-1:0]    PDG_ELE   = 24'd11;
   localparam logic [PdgW-1:0]    PDG_MUON  = 24'd13;

   localparam logic [PtW-1:0]     ISO_MIN_PT_RST      = 16'd8;
   localparam logic [ConeW-1:0]   CONE_OUTER_SQ_RST   = 22'd2390;
   localparam logic [ConeW-1:0]   CONE_INNER_SQ_RST   = 22'd2;
   localparam logic [RatioW-1:0]  RATIO_MAX_RST       = 10'd59;
   localparam logic [PtW-1:0]     LEP_PT_MIN_RST      = 16'd160;
   localparam logic [AbsEtaW-1:0] LEP_ABS_ETA_MIN_RST = 10'd130;
   localparam logic [AbsEtaW-1:0] LEP_ABS_ETA_MAX_RST = 10'd235;

   typedef enum logic [1:0] {
      FUNC_LEPTON  = 2'd0,
      FUNC_TRACK   = 2'd1,
      FUNC_NEUTRAL = 2'd2,
      FUNC_FINISH  = 2'd3
   } func_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ISO_MIN_PT      = 3'd0,
      CSR_CONE_OUTER_SQ   = 3'd1,
      CSR_CONE_INNER_SQ   = 3'd2,
      CSR_RATIO_MAX       = 3'd3,
      CSR_LEP_PT_MIN      = 3'd4,
      CSR_LEP_ABS_ETA_MIN = 3'd5,
      CSR_LEP_ABS_ETA_MAX = 3'd6,
      CSR_SKIP_ISOLATION  = 3'd7
   } csr_index_type;

   // input item as captured in the input register
   typedef struct packed {
      logic [1:0]             func;
      logic [PtW-1:0]         pt;
      logic signed [EtaW-1:0] eta;
      logic [PhiW-1:0]        phi;
      logic signed [PdgW-1:0] pdg_id;
   } item_type;

endpackage

// ===== hdl/lci_if.sv =====
// Valid/ready channel interfaces for the lepton cone isolation block.
// Depends on lci_pkg for field widths.
`timescale 1ns / 1ps

interface lci_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            func;
   logic [lci_pkg::PtW-1:0]               pt;
   logic signed [lci_pkg::EtaW-1:0]       eta;
   logic [lci_pkg::PhiW-1:0]              phi;
   logic signed [lci_pkg::PdgW-1:0]       pdg_id;

   modport source (output valid, func, pt, eta, phi, pdg_id, input ready);
   modport sink (input valid, func, pt, eta, phi, pdg_id, output ready);
endinterface

interface lci_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kinematic_ok;
   logic                        isolated;
   logic                        accepted;
   logic [lci_pkg::SumW-1:0]    sum_pt;

   modport source (output valid, kinematic_ok, isolated, accepted, sum_pt, input ready);
   modport sink (input valid, kinematic_ok, isolated, accepted, sum_pt, output ready);
endinterface

// ===== hdl/lepton_cone_isolation.sv =====
// Lepton cone isolation: input register, one combinational pass, result register.
// Depends on lci_pkg, the channel interfaces in lci_if.sv and the assertion header.
`timescale 1ns / 1ps
//
// Usage:
//   req carries lepton, track, neutral and finish items; rsp carries one decision
//   per finish item. Configuration is written through csr_wr_en/csr_index/csr_wdata
//   while the block is idle.
//   A lepton item loads the candidate and clears the cone sum; track and neutral items
//   over the pt floor add pt when they sit in the delta-R annulus, tracks with e/mu ids
//   apart; a finish reports kinematic_ok, isolated, accepted and sum_pt for the current lepton.
// Timing:
//   One item per cycle while no finish item waits on a stalled result register. An
//   item lands in the input register; when it moves on, it updates the lepton state
//   and cone sum and, for a finish item, loads the result register, from which the
//   finish result shows on rsp.
// Reset:
//   Synchronous, active high. Clears the input and result valid flags, the lepton
//   state and the sum, and loads the register defaults.
// Backpressure:
//   A stalled result register holds its result; non-finish items keep flowing,
//   and req drops ready only while a finish item waits in the input register.

module lepton_cone_isolation (
   input  logic                           clock,
   input  logic                           reset,
   lci_req_if.sink                        req,
   lci_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [lci_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [lci_pkg::CsrDataW-1:0]   csr_wdata
);
   import lci_pkg::*;

   // configuration
   logic [PtW-1:0]     iso_min_pt_ff;
   logic [ConeW-1:0]   cone_outer_sq_ff;
   logic [ConeW-1:0]   cone_inner_sq_ff;
   logic [RatioW-1:0]  ratio_max_ff;
   logic [PtW-1:0]     lep_pt_min_ff;
   logic [AbsEtaW-1:0] lep_abs_eta_min_ff;
   logic [AbsEtaW-1:0] lep_abs_eta_max_ff;
   logic               skip_isolation_ff;

   // lepton state and cone sum
   logic [PtW-1:0]         lep_pt_ff, lep_pt_in;
   logic signed [EtaW-1:0] lep_eta_ff, lep_eta_in;
   logic [PhiW-1:0]        lep_phi_ff, lep_phi_in;
   logic                   lep_kin_ff, lep_kin_in;
   logic [SumW-1:0]        cone_sum_ff, cone_sum_in;

   // input and result registers
   logic     p0_valid_ff, p0_valid_in;
   item_type p0_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_kin_ff, rsp_iso_ff, rsp_acc_ff;
   logic     rsp_kin_in, rsp_iso_in, rsp_acc_in;
   logic [SumW-1:0] rsp_sum_ff;

   logic out_free, a_move, a_free, req_xfer;

   // geometry
   logic [EtaW-1:0]          abs_eta;
   logic                     kin_ok;
   logic signed [EtaW:0]     deta;
   logic signed [2*EtaW+1:0] deta_prod;
   logic [PhiW-1:0]          dphi_raw;
   logic signed [PhiW-1:0]   dphi;
   logic signed [2*PhiW-1:0] dphi_prod;
   logic [DrW-1:0]           dr_sq;
   logic                     pdg_skip;
   logic                     in_cone;
   logic                     add_pt;

   // accumulate and decision
   logic [ProdW-1:0]     limit;
   logic [SumW:0]        sum_wide;
   logic [SumW+7:0]      sum_scaled;
   logic                 iso_ok;

   // ---------------- handshake ----------------
   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      a_move   = p0_valid_ff && (func_type'(p0_ff.func) != FUNC_FINISH || out_free);
      a_free   = !p0_valid_ff || a_move;
      req_xfer = req.valid && a_free;
   end

   assign req.ready = a_free;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         iso_min_pt_ff      <= ISO_MIN_PT_RST;
         cone_outer_sq_ff   <= CONE_OUTER_SQ_RST;
         cone_inner_sq_ff   <= CONE_INNER_SQ_RST;
         ratio_max_ff       <= RATIO_MAX_RST;
         lep_pt_min_ff      <= LEP_PT_MIN_RST;
         lep_abs_eta_min_ff <= LEP_ABS_ETA_MIN_RST;
         lep_abs_eta_max_ff <= LEP_ABS_ETA_MAX_RST;
         skip_isolation_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ISO_MIN_PT:      iso_min_pt_ff      <= csr_wdata[PtW-1:0];
            CSR_CONE_OUTER_SQ:   cone_outer_sq_ff   <= csr_wdata[ConeW-1:0];
            CSR_CONE_INNER_SQ:   cone_inner_sq_ff   <= csr_wdata[ConeW-1:0];
            CSR_RATIO_MAX:       ratio_max_ff       <= csr_wdata[RatioW-1:0];
            CSR_LEP_PT_MIN:      lep_pt_min_ff      <= csr_wdata[PtW-1:0];
            CSR_LEP_ABS_ETA_MIN: lep_abs_eta_min_ff <= csr_wdata[AbsEtaW-1:0];
            CSR_LEP_ABS_ETA_MAX: lep_abs_eta_max_ff <= csr_wdata[AbsEtaW-1:0];
            CSR_SKIP_ISOLATION:  skip_isolation_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   assign p0_valid_in = req_xfer || (p0_valid_ff && !a_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= p0_valid_in;
      end
      if (req_xfer) begin
         p0_ff.func   <= req.func;
         p0_ff.pt     <= req.pt;
         p0_ff.eta    <= req.eta;
         p0_ff.phi    <= req.phi;
         p0_ff.pdg_id <= req.pdg_id;
      end
   end

   // ---------------- single pass ----------------
   always_comb begin
      abs_eta = p0_ff.eta[EtaW-1] ? EtaW'(-p0_ff.eta) : EtaW'(p0_ff.eta);
      kin_ok  = (p0_ff.pt >= lep_pt_min_ff)
             && (abs_eta <= {1'b0, lep_abs_eta_max_ff})
             && (abs_eta >= {1'b0, lep_abs_eta_min_ff})
             && !(abs_eta >= CRACK_LO && abs_eta <= CRACK_HI);

      deta      = {p0_ff.eta[EtaW-1], p0_ff.eta} - {lep_eta_ff[EtaW-1], lep_eta_ff};
      deta_prod = deta * deta;
      // phi wraps: the modular difference read as signed is the short way round
      dphi_raw  = p0_ff.phi - lep_phi_ff;
      dphi      = signed'(dphi_raw);
      dphi_prod = dphi * dphi;
      dr_sq     = {1'b0, deta_prod[ConeW-1:0]} + DrW'(dphi_prod[2*PhiW-2:0]);

      pdg_skip = (p0_ff.pdg_id == PDG_ELE)  || (p0_ff.pdg_id == -PDG_ELE)
              || (p0_ff.pdg_id == PDG_MUON) || (p0_ff.pdg_id == -PDG_MUON);
      in_cone  = (dr_sq < {1'b0, cone_outer_sq_ff})
              && (dr_sq > {1'b0, cone_inner_sq_ff})
              && (p0_ff.pt > iso_min_pt_ff);

      case (func_type'(p0_ff.func))
         FUNC_TRACK:   add_pt = in_cone && !pdg_skip;
         FUNC_NEUTRAL: add_pt = in_cone;
         default:      add_pt = 1'b0;
      endcase

      limit      = ratio_max_ff * lep_pt_ff;
      sum_wide   = {1'b0, cone_sum_ff} + (SumW+1)'(p0_ff.pt);
      sum_scaled = {cone_sum_ff, 8'd0};
      iso_ok     = (lep_pt_ff != '0) && (sum_scaled <= (SumW+8)'(limit));

      lep_pt_in   = lep_pt_ff;
      lep_eta_in  = lep_eta_ff;
      lep_phi_in  = lep_phi_ff;
      lep_kin_in  = lep_kin_ff;
      cone_sum_in = cone_sum_ff;
      if (a_move) begin
         if (func_type'(p0_ff.func) == FUNC_LEPTON) begin
            lep_pt_in   = p0_ff.pt;
            lep_eta_in  = p0_ff.eta;
            lep_phi_in  = p0_ff.phi;
            lep_kin_in  = kin_ok;
            cone_sum_in = '0;
         end else if (add_pt) begin
            // saturate at full scale
            cone_sum_in = sum_wide[SumW] ? SUM_MAX : sum_wide[SumW-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (a_move && func_type'(p0_ff.func) == FUNC_FINISH) begin
         rsp_valid_in = 1'b1;
      end
      rsp_kin_in = lep_kin_ff;
      rsp_iso_in = iso_ok;
      rsp_acc_in = lep_kin_ff && (iso_ok || skip_isolation_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lep_pt_ff    <= '0;
         lep_eta_ff   <= '0;
         lep_phi_ff   <= '0;
         lep_kin_ff   <= 1'b0;
         cone_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lep_pt_ff    <= lep_pt_in;
         lep_eta_ff   <= lep_eta_in;
         lep_phi_ff   <= lep_phi_in;
         lep_kin_ff   <= lep_kin_in;
         cone_sum_ff  <= cone_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (a_move && func_type'(p0_ff.func) == FUNC_FINISH) begin
         rsp_kin_ff <= rsp_kin_in;
         rsp_iso_ff <= rsp_iso_in;
         rsp_acc_ff <= rsp_acc_in;
         rsp_sum_ff <= cone_sum_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kinematic_ok = rsp_kin_ff;
   assign rsp.isolated     = rsp_iso_ff;
   assign rsp.accepted     = rsp_acc_ff;
   assign rsp.sum_pt       = rsp_sum_ff;

   // ---------------- checks ----------------
`include "lepton_cone_isolation_assert.svh"

   `LCI_ASSERT_NXT_NR(a_sum_reset, reset, cone_sum_ff == '0)
   `LCI_ASSERT_NXT(a_sum_clear, a_move && func_type'(p0_ff.func) == FUNC_LEPTON, cone_sum_ff == '0)
   `LCI_ASSERT_NXT(a_sum_grows, a_move && add_pt, cone_sum_ff >= $past(cone_sum_ff))
   `LCI_ASSERT_IMP(a_acc_needs_kin, rsp_valid_ff && rsp_acc_ff, rsp_kin_ff)

endmodule

// ===== tb/sv/lepton_cone_isolation_test.sv =====
// Self-checking testbench for lepton_cone_isolation: random bursts of lepton, track,
// neutral and finish transfers checked against a cycle-free predictor of the decision.
// Depends on lci_pkg, the channel interfaces in lci_if.sv and the lepton_cone_isolation RTL.
`timescale 1ns / 1ps

module lepton_cone_isolation_test;
   import lci_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int PIPE_SETTLE     = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int PHASES          = 8;
   localparam int PRINT_CAP       = 30;

   typedef struct packed {
      logic            kinematic_ok;
      logic            isolated;
      logic            accepted;
      logic [SumW-1:0] sum_pt;
   } decision_type;

   logic clock = 1'b0;
   logic reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   lci_req_if req_ch ();
   lci_rsp_if rsp_ch ();

   lepton_cone_isolation i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [PtW-1:0]     cfg_iso_min_pt   = ISO_MIN_PT_RST;
   logic [ConeW-1:0]   cfg_cone_outer   = CONE_OUTER_SQ_RST;
   logic [ConeW-1:0]   cfg_cone_inner   = CONE_INNER_SQ_RST;
   logic [RatioW-1:0]  cfg_ratio_max    = RATIO_MAX_RST;
   logic [PtW-1:0]     cfg_lep_pt_min   = LEP_PT_MIN_RST;
   logic [AbsEtaW-1:0] cfg_eta_min      = LEP_ABS_ETA_MIN_RST;
   logic [AbsEtaW-1:0] cfg_eta_max      = LEP_ABS_ETA_MAX_RST;
   logic               cfg_skip_iso     = 1'b0;

   // predictor copy of the lepton and cone state
   logic [PtW-1:0]         lepton_pt   = '0;
   logic signed [EtaW-1:0] lepton_eta  = '0;
   logic [PhiW-1:0]        lepton_phi  = '0;
   logic                   lepton_kin  = 1'b0;
   logic [SumW-1:0]        cone_sum    = '0;

   item_type     items_to_send[$];
   decision_type decisions_due[$];

   int  mismatches  = 0;
   int  idle_cycles = 0;
   logic req_fired  = 1'b0;
   int  burst_left  = 0;
   int  gap_left    = 0;
   int  ready_run   = 0;
   logic ready_level = 1'b1;
   item_type     next_item;
   decision_type want;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // append one item to the tail of the send queue
   function automatic void queue_item(input item_type it);
      items_to_send.insert(items_to_send.size(), it);
   endfunction

   function automatic item_type make_item(input func_type f, input int unsigned pt,
                                          input int eta, input int unsigned phi,
                                          input int pdg);
      item_type it;
      it.func   = f;
      it.pt     = pt[PtW-1:0];
      it.eta    = eta[EtaW-1:0];
      it.phi    = phi[PhiW-1:0];
      it.pdg_id = pdg[PdgW-1:0];
      return it;
   endfunction

   // Advance the lepton/cone state by one transfer; queue a decision for finish.
   task automatic predict_isolation(input item_type it);
      int e, a_eta, d_eta, d_phi, pdg_mag;
      int unsigned d2, grown;
      logic ok, iso;
      decision_type d;
      e = $signed(it.eta);
      case (func_type'(it.func)) inside
         FUNC_LEPTON: begin
            a_eta = (e < 0) ? -e : e;
            ok = (it.pt >= cfg_lep_pt_min) && (a_eta <= cfg_eta_max) &&
                 (a_eta >= cfg_eta_min) && !(a_eta >= CRACK_LO && a_eta <= CRACK_HI);
            lepton_pt  = it.pt;
            lepton_eta = it.eta;
            lepton_phi = it.phi;
            lepton_kin = ok;
            cone_sum   = '0;
         end
         FUNC_TRACK, FUNC_NEUTRAL: begin
            pdg_mag = $signed(it.pdg_id);
            if (pdg_mag < 0) pdg_mag = -pdg_mag;
            if (!(func_type'(it.func) == FUNC_TRACK &&
                  (pdg_mag == PDG_ELE || pdg_mag == PDG_MUON))) begin
               d_eta = e - $signed(lepton_eta);
               d_phi = (int'(it.phi) - int'(lepton_phi)) & 1023;
               if (d_phi >= 512) d_phi -= 1024;
               d2 = d_eta * d_eta + d_phi * d_phi;
               if (d2 < cfg_cone_outer && d2 > cfg_cone_inner && it.pt > cfg_iso_min_pt) begin
                  grown = cone_sum + it.pt;
                  cone_sum = (grown > SUM_MAX) ? SUM_MAX : grown[SumW-1:0];
               end
            end
         end
         default: begin
            iso = (lepton_pt != 0) &&
                  (longint'(cone_sum) * 256 <= longint'(cfg_ratio_max) * longint'(lepton_pt));
            d.kinematic_ok = lepton_kin;
            d.isolated     = iso;
            d.accepted     = lepton_kin & (iso | cfg_skip_iso);
            d.sum_pt       = cone_sum;
            decisions_due.insert(decisions_due.size(), d);
         end
      endcase
   endtask

   // One lepton with candidates around it and a finish, sometimes a second; heavy ones push the sum toward saturation.
   function automatic int queue_event(input bit heavy);
      int unsigned pt_l, a_eta, phi_l, span, cand_pt, n;
      int eta_l, pdg, count;
      func_type f;
      pt_l = cfg_lep_pt_min + $urandom_range(0, 3000);
      if (pt_l > 65535) pt_l = 65535;
      if ($urandom_range(0, 9) == 0) pt_l = $urandom_range(0, 65535);
      if (cfg_eta_min <= cfg_eta_max && $urandom_range(0, 9) != 0)
         a_eta = $urandom_range(cfg_eta_max, cfg_eta_min);
      else
         a_eta = $urandom_range(0, 1023);
      eta_l = $urandom_range(0, 1) ? -int'(a_eta) : int'(a_eta);
      phi_l = $urandom_range(0, 1023);
      queue_item(make_item(FUNC_LEPTON, pt_l, eta_l, phi_l, $urandom));
      n = heavy ? 20 : $urandom_range(0, 10);
      span = heavy ? 5 : $urandom_range(3, 80);
      count = 1;
      repeat (n) begin
         f = $urandom_range(0, 1) ? FUNC_TRACK : FUNC_NEUTRAL;
         case ($urandom_range(0, 7))
            0: pdg = 11;
            1: pdg = -11;
            2: pdg = 13;
            3: pdg = -13;
            4: pdg = 211;
            5: pdg = -321;
            6: pdg = 22;
            default: pdg = $urandom;
         endcase
         cand_pt = heavy ? $urandom_range(50000, 65535) : $urandom_range(0, pt_l / 5 + 20);
         queue_item(make_item(f, cand_pt,
            eta_l + int'($urandom_range(0, 2 * span)) - int'(span),
            (phi_l + $urandom_range(0, 2 * span) - span) & 1023, pdg));
         count++;
      end
      queue_item(make_item(FUNC_FINISH, $urandom, $urandom, $urandom, $urandom));
      count++;
      if ($urandom_range(0, 9) == 0) begin
         queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
         count++;
      end
      return count;
   endfunction

   task automatic write_reg(input csr_index_type idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CsrDataW-1:0];
      case (idx)
         CSR_ISO_MIN_PT:      cfg_iso_min_pt = val[PtW-1:0];
         CSR_CONE_OUTER_SQ:   cfg_cone_outer = val[ConeW-1:0];
         CSR_CONE_INNER_SQ:   cfg_cone_inner = val[ConeW-1:0];
         CSR_RATIO_MAX:       cfg_ratio_max  = val[RatioW-1:0];
         CSR_LEP_PT_MIN:      cfg_lep_pt_min = val[PtW-1:0];
         CSR_LEP_ABS_ETA_MIN: cfg_eta_min    = val[AbsEtaW-1:0];
         CSR_LEP_ABS_ETA_MAX: cfg_eta_max    = val[AbsEtaW-1:0];
         default:             cfg_skip_iso   = val[0];
      endcase
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (items_to_send.size() != 0 || req_ch.valid || decisions_due.size() != 0);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fired) begin
         // hold until the transfer happens
      end else if (gap_left != 0) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
         next_item = items_to_send.pop_front();
         req_ch.valid  <= 1'b1;
         req_ch.func   <= next_item.func;
         req_ch.pt     <= next_item.pt;
         req_ch.eta    <= next_item.eta;
         req_ch.phi    <= next_item.phi;
         req_ch.pdg_id <= next_item.pdg_id;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // receiver: runs of ready and stall, with occasional long ready stretches
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_run = $urandom_range(1, 10);
         ready_level = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) begin
            ready_level = 1'b1;
            ready_run = 40;
         end
      end
      ready_run--;
      rsp_ch.ready <= reset ? 1'b0 : ready_level;
   end

   // monitor: predict on req transfers, check on rsp transfers
   always @(posedge clock) begin
      req_fired <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_isolation(make_item(func_type'(req_ch.func), req_ch.pt, $signed(req_ch.eta),
                                     req_ch.phi, $signed(req_ch.pdg_id)));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decisions_due.size() == 0) begin
            report_mismatch("result transfer with no finish item outstanding");
         end else begin
            want = decisions_due.pop_front();
            if (rsp_ch.kinematic_ok !== want.kinematic_ok)
               report_mismatch($sformatf("kinematic_ok got %0b expected %0b",
                                         rsp_ch.kinematic_ok, want.kinematic_ok));
            if (rsp_ch.isolated !== want.isolated)
               report_mismatch($sformatf("isolated got %0b expected %0b",
                                         rsp_ch.isolated, want.isolated));
            if (rsp_ch.accepted !== want.accepted)
               report_mismatch($sformatf("accepted got %0b expected %0b",
                                         rsp_ch.accepted, want.accepted));
            if (rsp_ch.sum_pt !== want.sum_pt)
               report_mismatch($sformatf("sum_pt got %0d expected %0d",
                                         rsp_ch.sum_pt, want.sum_pt));
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("lepton_cone_isolation verification failed");
      $finish;
   end

   initial begin
      int unsigned regs[8];
      int unsigned wp[5];
      int queued, pick, n;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.pt = '0;
      req_ch.eta = '0;
      req_ch.phi = '0;
      req_ch.pdg_id = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            // finish and candidates before any lepton use the zeroed lepton
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
            queue_item(make_item(FUNC_NEUTRAL, 100, 10, 5, 0));
            queue_item(make_item(FUNC_TRACK, 65535, -3, 1022, 211));
            queue_item(make_item(FUNC_FINISH, 65535, 1023, 1023, -1));
            // passing lepton at the phi seam, skipped ids, pt floor, inner edge, far side
            queue_item(make_item(FUNC_LEPTON, 65535, 200, 1023, 0));
            queue_item(make_item(FUNC_TRACK, 500, 201, 2, 11));
            queue_item(make_item(FUNC_TRACK, 500, 201, 2, -13));
            queue_item(make_item(FUNC_TRACK, 500, 201, 2, -11));
            queue_item(make_item(FUNC_TRACK, 900, 205, 3, 211));
            queue_item(make_item(FUNC_NEUTRAL, 8, 201, 1023, 0));
            queue_item(make_item(FUNC_NEUTRAL, 9, 201, 0, 0));
            queue_item(make_item(FUNC_NEUTRAL, 9, 201, 1, 0));
            queue_item(make_item(FUNC_NEUTRAL, 1000, 200, 511, 0));
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
            // zero-pt lepton at the most negative eta, still accumulating
            queue_item(make_item(FUNC_LEPTON, 0, -1024, 0, 0));
            queue_item(make_item(FUNC_NEUTRAL, 65535, -1020, 0, 0));
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
            // lepton in the crack
            queue_item(make_item(FUNC_LEPTON, 200, 240, 100, 0));
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
            // lepton on the window edges, extreme track ids
            queue_item(make_item(FUNC_LEPTON, 160, -130, 512, 0));
            queue_item(make_item(FUNC_TRACK, 30, -128, 500, -8388608));
            queue_item(make_item(FUNC_TRACK, 30, -131, 513, 8388607));
            queue_item(make_item(FUNC_FINISH, 0, 0, 0, 0));
         end else begin
            wait_idle();
            repeat (PIPE_SETTLE) @(posedge clock);
            wp = '{23, 154, 97, 0, $urandom_range(0, 1023)};
            if (phase == 1) begin
               regs = '{0, 0, 0, 0, 0, 0, 0, 0};
            end else if (phase == 2) begin
               regs = '{65535, 4194303, 4194303, 1023, 65535, 1023, 1023, 1};
            end else begin
               regs[0] = $urandom_range(0, 200);
               regs[1] = $urandom_range(50, 20000);
               regs[2] = $urandom_range(0, 60);
               regs[3] = wp[phase - 3];
               regs[4] = $urandom_range(0, 800);
               regs[5] = $urandom_range(0, 180);
               regs[6] = $urandom_range(150, 1023);
               regs[7] = phase % 2;
            end
            for (int k = 0; k < 8; k++) write_reg(csr_index_type'(k), regs[k]);
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end

         queued = 0;
         while (queued < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               queued += queue_event(1'b1);
            end else if (pick < 85) begin
               queued += queue_event(1'b0);
            end else begin
               // noise: unrelated transfers, broken sequences
               n = $urandom_range(1, 4);
               repeat (n) begin
                  queue_item(make_item(func_type'($urandom_range(0, 3)),
                     $urandom_range(0, 65535), $urandom_range(0, 2047),
                     $urandom_range(0, 1023), $urandom));
               end
               queued += n;
            end
         end
      end

      wait_idle();
      repeat (PIPE_SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("lepton_cone_isolation verification clean");
      else
         $display("lepton_cone_isolation verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lci_pkg.sv
hdl/lci_if.sv
hdl/lepton_cone_isolation.sv
tb/sv/lepton_cone_isolation_test.sv
